@@ hdl/lpit_pkg.sv @@
// Package for the linear-probe intern table: sizes, operation and status codes.
// No dependencies; used by lpit_store, linear_probe_intern_table and the bench.
package lpit_pkg;
	localparam int SLOTS = 256;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W = SLOT_W + 1;
	localparam int KEY_W = 64;
	localparam int TYPE_W = 8;

	localparam logic [1:0] OP_INTERN = 2'd0;
	localparam logic [1:0] OP_PROBE = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	// The spare code behaves as a probe.
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic [2:0] ST_FOUND = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_ABSENT = 3'd2;
	localparam logic [2:0] ST_REMOVED = 3'd3;
	localparam logic [2:0] ST_RM_MISS = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TYPE_W-1:0] typ;
		logic [SLOT_W-1:0] home;
	} entry_t;

	typedef struct packed {
		logic wr;
		logic [SLOT_W-1:0] waddr;
		entry_t wdata;
		logic [SLOT_W-1:0] raddr;
	} store_req_t;
endpackage

@@ hdl/lpit_store.sv @@
// Entry memory of the intern table: one write port and one registered read port.
// Depends on lpit_pkg.
module lpit_store
	import lpit_pkg::*;
(
	input logic clk,
	input store_req_t req,
	output entry_t rdata
);
	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule

@@ hdl/linear_probe_intern_table.sv @@
// Linear-probe intern table, top level. Depends on lpit_pkg and lpit_store.
// A search reads and evaluates each slot that it examines in turn, then strobes
// its result; a remove first scans the slots of the backward shift, the closing
// empty slot included. busy stays high through the result cycle, so the next
// word is taken in the cycle after the strobe at the earliest. Reset clears the
// used bits and live count at once; the entry memory is not cleared.
module linear_probe_intern_table
	import lpit_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] op,
	input logic [KEY_W-1:0] key,
	input logic [TYPE_W-1:0] type_code,
	input logic [31:0] hash,
	output logic done,
	output logic [2:0] status,
	output logic [7:0] slot_index,
	output logic [8:0] entry_count,
	output logic over_half
);
	// The sequencer walks one slot at a time: issue a read, then
	// evaluate the returned entry with the single comparator/distance unit.
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SRD = 6'b000010,
		S_SEV = 6'b000100,
		S_GRD = 6'b001000,
		S_GEV = 6'b010000,
		S_OUT = 6'b100000
	} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic [KEY_W-1:0] key_q;
	logic [TYPE_W-1:0] type_q;
	logic [SLOT_W-1:0] home_q;
	logic [SLOT_W-1:0] cur_q;   // search position, then gap position
	logic [SLOT_W-1:0] scan_q;  // backward-shift scan position
	logic [CNT_W-1:0] n_q;      // bound on steps
	logic [CNT_W-1:0] live_q;
	logic [SLOTS-1:0] used_q;
	logic [2:0] status_q;
	logic [SLOT_W-1:0] where_q;

	store_req_t req;
	entry_t rdata;

	lpit_store u_store (
		.clk(clk),
		.req(req),
		.rdata(rdata)
	);

	// Shared evaluation unit.
	logic hit;
	logic [SLOT_W-1:0] dh, dg;
	assign hit = (rdata.key == key_q) && (rdata.typ == type_q);
	// Modular differences wrap naturally at SLOT_W bits.
	assign dh = rdata.home - scan_q;
	assign dg = cur_q - scan_q;

	logic [SLOT_W-1:0] scan_next;
	assign scan_next = scan_q - 1'b1;

	always_comb begin
		req = '0;
		req.raddr = (state_q == S_SRD) ? cur_q : scan_q;
		if (state_q == S_GEV && used_q[scan_q] && n_q != CNT_W'(SLOTS - 1)
				&& dh >= dg) begin
			req.wr = 1'b1;
			req.waddr = cur_q;
			req.wdata = rdata;
		end else if (state_q == S_SEV && !used_q[cur_q] && op_q == OP_INTERN
				&& live_q < CNT_W'(SLOTS - 1)) begin
			req.wr = 1'b1;
			req.waddr = cur_q;
			req.wdata.key = key_q;
			req.wdata.typ = type_q;
			req.wdata.home = home_q;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			live_q <= '0;
			op_q <= OP_INTERN;
			key_q <= '0;
			type_q <= '0;
			home_q <= '0;
			cur_q <= '0;
			scan_q <= '0;
			n_q <= '0;
			status_q <= ST_FOUND;
			where_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// Payload registers are loaded at acceptance.
					if (start) begin
						state_q <= S_SRD;
						op_q <= op;
						key_q <= key;
						type_q <= type_code;
						home_q <= hash[SLOT_W-1:0];
						cur_q <= hash[SLOT_W-1:0];
						where_q <= hash[SLOT_W-1:0];
						n_q <= '0;
					end
				end
				S_SRD: begin
					// Unused slots need no read; the evaluation checks used_q first.
					state_q <= S_SEV;
				end
				S_SEV: begin
					if (!used_q[cur_q]) begin
						state_q <= S_OUT;
						if (op_q == OP_INTERN) begin
							if (live_q >= CNT_W'(SLOTS - 1)) begin
								status_q <= ST_FULL;
							end else begin
								used_q[cur_q] <= 1'b1;
								live_q <= live_q + 1'b1;
								status_q <= ST_INSERTED;
							end
						end else if (op_q == OP_REMOVE) begin
							status_q <= ST_RM_MISS;
						end else begin
							status_q <= ST_ABSENT;
						end
					end else if (hit) begin
						if (op_q == OP_REMOVE) begin
							used_q[cur_q] <= 1'b0;
							if (live_q != '0) begin
								live_q <= live_q - 1'b1;
							end
							status_q <= ST_REMOVED;
							scan_q <= cur_q - 1'b1;
							n_q <= '0;
							state_q <= S_GRD;
						end else begin
							status_q <= ST_FOUND;
							state_q <= S_OUT;
						end
					end else if (n_q == CNT_W'(SLOTS - 1)) begin
						// Whole table walked without an empty slot.
						where_q <= '0;
						state_q <= S_OUT;
						status_q <= (op_q == OP_REMOVE) ? ST_RM_MISS :
							(op_q == OP_INTERN) ? ST_FULL : ST_ABSENT;
					end else begin
						cur_q <= cur_q - 1'b1;
						where_q <= cur_q - 1'b1;
						n_q <= n_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_GRD: begin
					state_q <= S_GEV;
				end
				S_GEV: begin
					if (!used_q[scan_q] || n_q == CNT_W'(SLOTS - 1)) begin
						state_q <= S_OUT;
					end else begin
						if (dh >= dg) begin
							used_q[cur_q] <= 1'b1;
							used_q[scan_q] <= 1'b0;
							cur_q <= scan_q;
						end
						scan_q <= scan_next;
						n_q <= n_q + 1'b1;
						state_q <= S_GRD;
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = (state_q == S_OUT);
	assign status = status_q;
	assign slot_index = 8'(where_q);
	assign entry_count = 9'(live_q);
	assign over_half = (live_q > CNT_W'(SLOTS / 2));

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CNT_W'(SLOTS))
		else $error("live count exceeds table size");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_INSERTED) |-> (live_q != '0))
		else $error("insert left count zero");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");
endmodule

@@ sim/tb_linear_probe_intern_table.sv @@
// Testbench for linear_probe_intern_table: directed table, fill and drain, then
// random traffic, checked word by word against a model. Depends on lpit_pkg.
module tb_linear_probe_intern_table;
	import lpit_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] op;
	logic [KEY_W-1:0] key;
	logic [TYPE_W-1:0] type_code;
	logic [31:0] hash;
	logic done;
	logic [2:0] status;
	logic [7:0] slot_index;
	logic [8:0] entry_count;
	logic over_half;

	linear_probe_intern_table u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.key(key), .type_code(type_code), .hash(hash), .done(done),
		.status(status), .slot_index(slot_index), .entry_count(entry_count),
		.over_half(over_half)
	);

	// One answer word of the table, as the model predicts it.
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] slot;
		logic [8:0] count;
		logic half;
	} answer_t;

	// One row of the directed table. chk says the answer column is typed in.
	typedef struct {
		logic [1:0] op;
		logic [KEY_W-1:0] key;
		logic [TYPE_W-1:0] typ;
		logic [31:0] hash;
		bit chk;
		answer_t ans;
	} row_t;

	// The shadow copy of the table.
	bit shadow_used[SLOTS];
	logic [KEY_W-1:0] shadow_key[SLOTS];
	logic [TYPE_W-1:0] shadow_typ[SLOTS];
	logic [SLOT_W-1:0] shadow_home[SLOTS];
	int shadow_live;

	answer_t answers_due[$];
	int errors;
	int idle_cycles;
	int n_accepted;
	int n_checked;
	int n_inserted;
	int n_removed;
	int n_full;
	bit quiet;

	// Keys sent to intern, at most 400 held; reused so hits and removes occur.
	logic [KEY_W-1:0] pool_key[$];
	logic [TYPE_W-1:0] pool_typ[$];
	logic [31:0] pool_hash[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Slot below s, wrapping from slot 0 to the top slot.
	function automatic int slot_below(int s);
		return (s == 0) ? SLOTS - 1 : s - 1;
	endfunction

	// Walk down from home until the entry or an empty slot is met.
	function automatic bit lookup_chain(logic [KEY_W-1:0] k, logic [TYPE_W-1:0] t,
			int home, output int where);
		int s;
		s = home;
		for (int n = 0; n < SLOTS; n++) begin
			if (!shadow_used[s]) begin
				where = s;
				return 1'b0;
			end
			if (shadow_key[s] == k && shadow_typ[s] == t) begin
				where = s;
				return 1'b1;
			end
			s = slot_below(s);
		end
		where = 0;
		return 1'b0;
	endfunction

	// Clear a slot and shift later chain members back into the hole, so that
	// every remaining entry is still reachable from its home slot.
	function automatic void shift_back(int gap);
		int scan;
		int dist_home;
		int dist_gap;
		scan = gap;
		shadow_used[gap] = 1'b0;
		for (int n = 0; n < SLOTS; n++) begin
			scan = slot_below(scan);
			if (!shadow_used[scan])
				break;
			dist_home = (int'(shadow_home[scan]) + SLOTS - scan) % SLOTS;
			dist_gap = (gap + SLOTS - scan) % SLOTS;
			if (dist_home >= dist_gap) begin
				shadow_used[gap] = 1'b1;
				shadow_key[gap] = shadow_key[scan];
				shadow_typ[gap] = shadow_typ[scan];
				shadow_home[gap] = shadow_home[scan];
				shadow_used[scan] = 1'b0;
				gap = scan;
			end
		end
	endfunction

	// Apply one accepted word to the shadow table and return the answer.
	function automatic answer_t table_answer(logic [1:0] o, logic [KEY_W-1:0] k,
			logic [TYPE_W-1:0] t, logic [31:0] h);
		answer_t a;
		int home;
		int where;
		bit hit;
		home = h % SLOTS;
		hit = lookup_chain(k, t, home, where);
		if (o == OP_REMOVE) begin
			if (hit) begin
				shift_back(where);
				if (shadow_live > 0)
					shadow_live--;
				a.status = ST_REMOVED;
				n_removed++;
			end else begin
				a.status = ST_RM_MISS;
			end
		end else if (o == OP_INTERN) begin
			if (hit) begin
				a.status = ST_FOUND;
			end else if (shadow_live >= SLOTS - 1 || shadow_used[where]) begin
				a.status = ST_FULL;
				n_full++;
			end else begin
				shadow_used[where] = 1'b1;
				shadow_key[where] = k;
				shadow_typ[where] = t;
				shadow_home[where] = home[SLOT_W-1:0];
				shadow_live++;
				a.status = ST_INSERTED;
				n_inserted++;
			end
		end else begin
			// Probe, and the spare code, only look the word up.
			a.status = hit ? ST_FOUND : ST_ABSENT;
		end
		a.slot = where[7:0];
		a.count = shadow_live[8:0];
		a.half = shadow_live > SLOTS / 2;
		return a;
	endfunction

	// Random idle decision: about 7 in 100 unless in a quiet stretch.
	function automatic bit idle_now();
		return !quiet && ($urandom_range(99) < 7);
	endfunction

	// Present one word and hold it until the block takes it. The model is
	// updated at the accepting edge, ahead of the matching result. start stays
	// high after the accepting edge; an idle cycle or the caller lowers it.
	task automatic send_word(logic [1:0] o, logic [KEY_W-1:0] k,
			logic [TYPE_W-1:0] t, logic [31:0] h);
		while (idle_now()) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		key <= k;
		type_code <= t;
		hash <= h;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		answers_due.push_back(table_answer(o, k, t, h));
		n_accepted++;
		if (o == OP_INTERN && pool_key.size() < 400) begin
			pool_key.push_back(k);
			pool_typ.push_back(t);
			pool_hash.push_back(h);
		end
	endtask

	// Result checker: a strobe with nothing outstanding, or any differing
	// field, is a failure.
	always @(posedge clk) begin
		answer_t exp_ans;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d count=%0d half=%0d",
					$time, status, slot_index, entry_count, over_half);
				errors++;
			end else begin
				exp_ans = answers_due.pop_front();
				n_checked++;
				if (status !== exp_ans.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_ans.status, status);
					errors++;
				end
				if (slot_index !== exp_ans.slot) begin
					$display("%0t: slot_index expected %0d actual %0d", $time,
						exp_ans.slot, slot_index);
					errors++;
				end
				if (entry_count !== exp_ans.count) begin
					$display("%0t: entry_count expected %0d actual %0d", $time,
						exp_ans.count, entry_count);
					errors++;
				end
				if (over_half !== exp_ans.half) begin
					$display("%0t: over_half expected %0d actual %0d", $time,
						exp_ans.half, over_half);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles with neither an accepted word nor a result. A
	// remove in a nearly full table scans up to 256 slots twice, so the idle
	// limit below is far beyond any correct run.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time,
				answers_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Directed rows: reset answers and error codes are typed in.
	row_t dir_rows[$];

	task automatic add_row(logic [1:0] o, logic [KEY_W-1:0] k, logic [TYPE_W-1:0] t,
			logic [31:0] h, bit c, logic [2:0] s, logic [7:0] sl, logic [8:0] cn);
		row_t r;
		r.op = o;
		r.key = k;
		r.typ = t;
		r.hash = h;
		r.chk = c;
		r.ans = '{status: s, slot: sl, count: cn, half: 1'b0};
		dir_rows.push_back(r);
	endtask

	// Fill most of the table, then drain it, to reach the full refusal and
	// the over-half flag with long wrapping chains.
	task automatic fill_and_drain();
		logic [KEY_W-1:0] k[$];
		logic [31:0] h[$];
		int victim;
		for (int i = 0; i < SLOTS + 4; i++) begin
			k.push_back({$urandom, $urandom});
			h.push_back($urandom_range(7));
			send_word(OP_INTERN, k[i], 8'h5A, h[i]);
		end
		// The same words again: all found.
		for (int i = 0; i < 20; i++)
			send_word(OP_INTERN, k[i], 8'h5A, h[i]);
		while (k.size() > 0) begin
			victim = $urandom_range(k.size() - 1);
			send_word(OP_REMOVE, k[victim], 8'h5A, h[victim]);
			k.delete(victim);
			h.delete(victim);
		end
	endtask

	initial begin
		answer_t a;
		int pick;
		int r;
		logic [1:0] o;
		errors = 0;
		idle_cycles = 0;
		n_accepted = 0;
		n_checked = 0;
		n_inserted = 0;
		n_removed = 0;
		n_full = 0;
		quiet = 1'b0;
		shadow_live = 0;
		foreach (shadow_used[i])
			shadow_used[i] = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_INTERN;
		key = '0;
		type_code = '0;
		hash = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-table answers, field extremes, every op,
		// the spare op, tag mismatch, wrap from slot 0 to the top.
		add_row(OP_PROBE, 64'h0, 8'h00, 32'h0, 1, ST_ABSENT, 8'd0, 9'd0);
		add_row(OP_REMOVE, '1, 8'hFF, '1, 1, ST_RM_MISS, 8'd255, 9'd0);
		add_row(OP_INTERN, '1, 8'hFF, '1, 1, ST_INSERTED, 8'd255, 9'd1);
		add_row(OP_INTERN, '1, 8'hFF, '1, 1, ST_FOUND, 8'd255, 9'd1);
		add_row(OP_PROBE, '1, 8'hFE, '1, 1, ST_ABSENT, 8'd254, 9'd1);
		add_row(OP_INTERN, 64'h0, 8'h00, 32'h0, 1, ST_INSERTED, 8'd0, 9'd2);
		add_row(OP_INTERN, 64'h1, 8'h00, 32'h0, 0, 0, 0, 0);
		add_row(OP_INTERN, 64'h2, 8'h00, 32'h100, 0, 0, 0, 0);
		add_row(OP_SPARE, 64'h1, 8'h00, 32'h0, 0, 0, 0, 0);
		add_row(OP_PROBE, 64'h2, 8'h00, 32'hFFFF_FF00, 0, 0, 0, 0);
		add_row(OP_REMOVE, 64'h0, 8'h00, 32'h0, 0, 0, 0, 0);
		add_row(OP_PROBE, 64'h1, 8'h00, 32'h0, 0, 0, 0, 0);
		add_row(OP_PROBE, 64'h2, 8'h00, 32'h0, 0, 0, 0, 0);
		add_row(OP_INTERN, 64'h8000_0000_0000_0000, 8'h80, 32'h8000_0080, 0, 0, 0, 0);
		add_row(OP_INTERN, 64'h8000_0000_0000_0000, 8'h81, 32'h8000_0080, 0, 0, 0, 0);
		add_row(OP_REMOVE, 64'h8000_0000_0000_0000, 8'h80, 32'h0000_0080, 0, 0, 0, 0);
		add_row(OP_REMOVE, 64'h8000_0000_0000_0000, 8'h81, 32'h0000_0080, 0, 0, 0, 0);
		add_row(OP_REMOVE, '1, 8'hFF, 32'hFF, 0, 0, 0, 0);
		add_row(OP_REMOVE, 64'h1, 8'h00, 32'h0, 0, 0, 0, 0);
		add_row(OP_REMOVE, 64'h2, 8'h00, 32'h0, 0, 0, 0, 0);
		foreach (dir_rows[i]) begin
			// Typed-in answers are compared against the model as well, so a
			// wrong model and a wrong table row both show up here.
			send_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typ,
				dir_rows[i].hash);
			a = answers_due[$];
			if (dir_rows[i].chk && a !== dir_rows[i].ans) begin
				$display("%0t: row %0d expected %h model %h", $time, i,
					dir_rows[i].ans, a);
				errors++;
			end
		end

		// Hold off until every outstanding answer has come back.
		start <= 1'b0;
		do
			@(posedge clk);
		while (answers_due.size() != 0);

		fill_and_drain();

		// Random part: mostly interns, probes and removes of known words,
		// with fresh words and narrow hashes for crowded chains.
		pool_key.delete();
		pool_typ.delete();
		pool_hash.delete();
		for (int i = 0; i < 590; i++) begin
			quiet = (i >= 300 && i < 450);
			r = $urandom_range(99);
			o = (r < 45) ? OP_INTERN : (r < 65) ? OP_PROBE : (r < 97) ? OP_REMOVE : OP_SPARE;
			if (pool_key.size() > 0 && $urandom_range(99) < 55) begin
				pick = $urandom_range(pool_key.size() - 1);
				send_word(o, pool_key[pick], pool_typ[pick], pool_hash[pick]);
				if (o == OP_REMOVE) begin
					pool_key.delete(pick);
					pool_typ.delete(pick);
					pool_hash.delete(pick);
				end
			end else if ($urandom_range(1)) begin
				send_word(o, {$urandom, $urandom}, 8'($urandom_range(255)), $urandom);
			end else begin
				send_word(o, 64'($urandom_range(15)), 8'($urandom_range(3)),
					{8'($urandom_range(255)), 16'h0, 8'(160 + $urandom_range(15))});
			end
		end
		quiet = 1'b0;

		start <= 1'b0;
		do
			@(posedge clk);
		while (answers_due.size() != 0);
		repeat (20) @(posedge clk);
		$display("Covered %0d words: %0d inserts, %0d removes, %0d full refusals.",
			n_accepted, n_inserted, n_removed, n_full);
		$display("%0d answers compared, %0d mismatches.", n_checked, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
